[hdl/ppi_pkg.sv]
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants of the path point interpolator.
// ----------------------------------------------------------------------------
package ppi_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	localparam logic [1:0] STAT_INTERP = 2'd0;
	localparam logic [1:0] STAT_FIRST  = 2'd1;
	localparam logic [1:0] STAT_LAST   = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	// Q3.28 angle constants
	localparam logic signed [33:0] PI_Q     = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q = 34'sd1686629713;

	// interpolated fields, in processing order
	localparam logic [2:0] FLD_X     = 3'd0;
	localparam logic [2:0] FLD_Y     = 3'd1;
	localparam logic [2:0] FLD_HDG   = 3'd2;
	localparam logic [2:0] FLD_CURV  = 3'd3;
	localparam logic [2:0] FLD_RATE  = 3'd4;
	localparam logic [2:0] FLD_ACCEL = 3'd5;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [30:0] heading;
		logic signed [31:0] curv;
		logic signed [31:0] rate;
		logic signed [31:0] accel;
	} point_t;

	localparam int POINT_W = $bits(point_t);

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RD_CL,
		S_LATCH_CL,
		S_RD_LO,
		S_RD_HI,
		S_LATCH_HI,
		S_WEIGHT,
		S_DIV,
		S_HDG_WRAP,
		S_HDG_DIFF,
		S_LERP,
		S_LERP_WAIT,
		S_HDG_FIN,
		S_OUT
	} state_t;

	// map an angle into [-pi, pi); input lies within [-3pi, 3pi)
	function automatic logic signed [33:0] wrap_angle(input logic signed [33:0] a);
		logic signed [33:0] t;
		begin
			t = a + PI_Q;
			if (t < 0)
				t = t + TWO_PI_Q;
			else if (t >= TWO_PI_Q)
				t = t - TWO_PI_Q;
			return t - PI_Q;
		end
	endfunction

endpackage

[hdl/ppi_ram.sv]
// ----------------------------------------------------------------------------
// ppi_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hdl/ppi_div.sv]
// ----------------------------------------------------------------------------
// ppi_div
// Restoring divider for the weight: quotient of (num << W) / den, num < den.
// ----------------------------------------------------------------------------
module ppi_div #(
	parameter int W = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [32:0]   num,
	input  logic [32:0]   den,
	output logic          done,
	output logic [W-1:0]  quo
);
	localparam int CW = $clog2(W + 1);

	logic [33:0]   rem_q;
	logic [32:0]   den_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [33:0]   rem_sh;

	assign rem_sh = {rem_q[32:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			// shift in one quotient bit
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[hdl/ppi_lerp.sv]
// ----------------------------------------------------------------------------
// ppi_lerp
// Shared interpolation unit: a + floor(d * w / 2^W), multiply then add.
// ----------------------------------------------------------------------------
module ppi_lerp #(
	parameter int W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] a_in,
	input  logic signed [33:0] d_in,
	input  logic [W:0]         w_in,
	output logic               done,
	output logic signed [33:0] res
);
	localparam int PW = W + 36;

	logic signed [33:0]   a_q;
	logic signed [33:0]   d_q;
	logic [W:0]           w_q;
	logic signed [PW-1:0] prod_q;
	logic signed [33:0]   res_q;
	logic                 mul_q;
	logic                 add_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			add_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start;
			add_q  <= mul_q;
			done_q <= add_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			d_q <= d_in;
			w_q <= w_in;
		end
		if (mul_q)
			prod_q <= PW'(d_q * $signed({1'b0, w_q}));
		// arithmetic shift gives the floor
		if (add_q)
			res_q <= a_q + 34'(prod_q >>> W);
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

[hdl/path_point_interpolator.sv]
// A query runs a binary search (one RAM read and one compare per probe);
// between two stored points it then runs the weight divider, unless the
// weight is clamped, and six interpolations in turn through one multiplier.
// Append and clear leave the input ready. One item is in work at a time.
// Reset clears the point count and the handshake state; the point memory
// is not cleared and holds no valid data until written.
// ----------------------------------------------------------------------------
// path_point_interpolator
// Arc-length path store with binary search and linear interpolation.
// ----------------------------------------------------------------------------
module path_point_interpolator import ppi_pkg::*; #(
	parameter int MAX_POINTS       = 1024,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] arc_s,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [30:0] heading,
	input  logic signed [31:0] curvature,
	input  logic signed [31:0] curvature_rate,
	input  logic signed [31:0] curvature_accel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_s,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [30:0] out_heading,
	output logic signed [31:0] out_curvature,
	output logic signed [31:0] out_curvature_rate,
	output logic signed [31:0] out_curvature_accel,
	output logic [1:0]         status
);
	localparam int W  = WEIGHT_FRAC_BITS;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      first_q;
	logic [CW-1:0]      span_q;
	logic [CW-1:0]      probe;
	logic signed [31:0] q_q;
	point_t             lo_q, hi_q, wr_q;
	logic [1:0]         wstat_q;
	logic [W:0]         w_q;
	logic signed [33:0] a0w_q, a1w_q, dh_q;
	logic [2:0]         fld_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	point_t             ram_rdata;
	logic [POINT_W-1:0] ram_rbits;

	logic signed [33:0] num, den;
	logic               div_start, div_done;
	logic [W-1:0]       div_quo;
	logic               lerp_start, lerp_done;
	logic signed [33:0] lerp_a, lerp_d, lerp_res;
	logic               out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign probe    = first_q + (span_q >> 1);
	assign ram_we   = accept && opcode == OP_APPEND && count_q < CW'(MAX_POINTS);
	assign ram_rdata = point_t'(ram_rbits);
	assign num      = 34'(q_q) - 34'(lo_q.s);
	assign den      = 34'(hi_q.s) - 34'(lo_q.s);
	assign out_load = (state_q == S_OUT) && (!out_valid || out_ready);

	always_comb begin
		case (state_q)
			S_RD_CL:  ram_raddr = (first_q == '0) ? '0 : AW'(count_q - 1'b1);
			S_RD_LO:  ram_raddr = AW'(first_q - 1'b1);
			S_RD_HI:  ram_raddr = AW'(first_q);
			default:  ram_raddr = AW'(probe);
		endcase
	end

	ppi_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(count_q)),
		.wdata ({arc_s, pos_x, pos_y, heading, curvature, curvature_rate,
		         curvature_accel}),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	assign div_start = (state_q == S_WEIGHT) && !(den <= 0 || num <= 0) && (num < den);

	ppi_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num[32:0]),
		.den    (den[32:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		case (fld_q)
			FLD_X: begin
				lerp_a = 34'(lo_q.x);
				lerp_d = 34'(hi_q.x) - 34'(lo_q.x);
			end
			FLD_Y: begin
				lerp_a = 34'(lo_q.y);
				lerp_d = 34'(hi_q.y) - 34'(lo_q.y);
			end
			FLD_HDG: begin
				lerp_a = a0w_q;
				lerp_d = dh_q;
			end
			FLD_CURV: begin
				lerp_a = 34'(lo_q.curv);
				lerp_d = 34'(hi_q.curv) - 34'(lo_q.curv);
			end
			FLD_RATE: begin
				lerp_a = 34'(lo_q.rate);
				lerp_d = 34'(hi_q.rate) - 34'(lo_q.rate);
			end
			default: begin
				lerp_a = 34'(lo_q.accel);
				lerp_d = 34'(hi_q.accel) - 34'(lo_q.accel);
			end
		endcase
	end

	assign lerp_start = (state_q == S_LERP);

	ppi_lerp #(.W(W)) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.a_in   (lerp_a),
		.d_in   (lerp_d),
		.w_in   (w_q),
		.done   (lerp_done),
		.res    (lerp_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_QUERY)
					state_d = (count_q == '0) ? S_OUT : S_SRCH_RD;
			end
			S_SRCH_RD: begin
				if (span_q != '0)
					state_d = S_SRCH_CMP;
				else if (first_q == '0 || first_q >= count_q)
					state_d = S_RD_CL;
				else
					state_d = S_RD_LO;
			end
			S_SRCH_CMP:  state_d = S_SRCH_RD;
			S_RD_CL:     state_d = S_LATCH_CL;
			S_LATCH_CL:  state_d = S_OUT;
			S_RD_LO:     state_d = S_RD_HI;
			S_RD_HI:     state_d = S_LATCH_HI;
			S_LATCH_HI:  state_d = S_WEIGHT;
			S_WEIGHT:    state_d = div_start ? S_DIV : S_HDG_WRAP;
			S_DIV: begin
				if (div_done)
					state_d = S_HDG_WRAP;
			end
			S_HDG_WRAP:  state_d = S_HDG_DIFF;
			S_HDG_DIFF:  state_d = S_LERP;
			S_LERP:      state_d = S_LERP_WAIT;
			S_LERP_WAIT: begin
				if (lerp_done) begin
					if (fld_q == FLD_HDG)
						state_d = S_HDG_FIN;
					else if (fld_q == FLD_ACCEL)
						state_d = S_OUT;
					else
						state_d = S_LERP;
				end
			end
			S_HDG_FIN:   state_d = S_LERP;
			S_OUT: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && opcode == OP_CLEAR)
				count_q <= '0;
			else if (ram_we)
				count_q <= count_q + 1'b1;
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q     <= arc_s;
				first_q <= '0;
				span_q  <= count_q;
				fld_q   <= FLD_X;
				wr_q    <= '0;
				wstat_q <= STAT_EMPTY;
			end
			S_SRCH_CMP: begin
				// lower bound: move past the probe or narrow to its left
				if (ram_rdata.s < q_q) begin
					first_q <= probe + 1'b1;
					span_q  <= span_q - (span_q >> 1) - 1'b1;
				end else begin
					span_q <= span_q >> 1;
				end
			end
			S_SRCH_RD: begin
				if (span_q == '0)
					wstat_q <= (first_q == '0) ? STAT_FIRST :
					           (first_q >= count_q) ? STAT_LAST : STAT_INTERP;
			end
			S_LATCH_CL: wr_q <= ram_rdata;
			S_RD_HI:    lo_q <= ram_rdata;
			S_LATCH_HI: hi_q <= ram_rdata;
			S_WEIGHT: begin
				wr_q.s <= q_q;
				if (den <= 0 || num <= 0)
					w_q <= '0;
				else if (num >= den)
					w_q <= (W+1)'(1) << W;
			end
			S_DIV: begin
				if (div_done)
					w_q <= {1'b0, div_quo};
			end
			S_HDG_WRAP: begin
				a0w_q <= wrap_angle(34'(lo_q.heading));
				a1w_q <= wrap_angle(34'(hi_q.heading));
			end
			S_HDG_DIFF: begin
				// take the shorter arc
				if (a1w_q - a0w_q > PI_Q)
					dh_q <= a1w_q - a0w_q - TWO_PI_Q;
				else if (a1w_q - a0w_q < -PI_Q)
					dh_q <= a1w_q - a0w_q + TWO_PI_Q;
				else
					dh_q <= a1w_q - a0w_q;
			end
			S_LERP_WAIT: begin
				if (lerp_done) begin
					if (fld_q != FLD_HDG)
						fld_q <= fld_q + 1'b1;
					case (fld_q)
						FLD_X:    wr_q.x     <= lerp_res[31:0];
						FLD_Y:    wr_q.y     <= lerp_res[31:0];
						FLD_HDG:  a0w_q      <= lerp_res;
						FLD_CURV: wr_q.curv  <= lerp_res[31:0];
						FLD_RATE: wr_q.rate  <= lerp_res[31:0];
						default:  wr_q.accel <= lerp_res[31:0];
					endcase
				end
			end
			S_HDG_FIN: begin
				wr_q.heading <= 31'(wrap_angle(a0w_q));
				fld_q        <= fld_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_s               <= wr_q.s;
			out_x               <= wr_q.x;
			out_y               <= wr_q.y;
			out_heading         <= wr_q.heading;
			out_curvature       <= wr_q.curv;
			out_curvature_rate  <= wr_q.rate;
			out_curvature_accel <= wr_q.accel;
			status              <= wstat_q;
		end
	end
endmodule

[hdl/ppi_checker.sv]
// ----------------------------------------------------------------------------
// ppi_checker
// Port-level checks of the path point interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module ppi_checker import ppi_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         opcode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_s,
	input logic signed [31:0] out_x,
	input logic signed [30:0] out_heading,
	input logic [1:0]         status
);
	// hold a result until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(status))
		else $error("result dropped while stalled");

	// a query transaction blocks the input while it is searched
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
		else $error("input accepted during query");

	// an empty path returns zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> out_s == 0 && out_x == 0 && out_heading == 0)
		else $error("empty path result not zero");

	// a new result only follows a query transaction
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without query");
endmodule

bind path_point_interpolator ppi_checker u_ppi_checker (.*);

[tb/tb_path_point_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_point_interpolator
// Drives clear, append, query and no-op transactions into the path
// interpolator, predicts each query result from a private copy of the
// stored path, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module tb_path_point_interpolator import ppi_pkg::*;;

	localparam int       PATH_DEPTH  = 1024;
	localparam int       W_BITS      = 16;
	localparam longint   HDG_PI      = 843314857;
	localparam longint   HDG_TWO_PI  = 1686629713;
	localparam int       CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [31:0] s;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [30:0] hdg;
		logic signed [31:0] curv;
		logic signed [31:0] rate;
		logic signed [31:0] accel;
		logic [1:0]         status;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = OP_CLEAR;
	logic signed [31:0] arc_s = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [30:0] heading = '0;
	logic signed [31:0] curvature = '0;
	logic signed [31:0] curvature_rate = '0;
	logic signed [31:0] curvature_accel = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] out_s;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [30:0] out_heading;
	logic signed [31:0] out_curvature;
	logic signed [31:0] out_curvature_rate;
	logic signed [31:0] out_curvature_accel;
	logic [1:0]         status;

	point_t  path_pts [PATH_DEPTH];
	int      path_len = 0;
	lookup_t pending_lookups [$];
	int      err_count = 0;
	int      cycle_count = 0;
	int      items_sent = 0;
	bit      calm = 1'b0;

	path_point_interpolator u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 14);

	function automatic longint wrap_hdg(longint a);
		longint r;
		r = (a + HDG_PI) % HDG_TWO_PI;
		if (r < 0)
			r += HDG_TWO_PI;
		return r - HDG_PI;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + (((b - a) * w) >>> W_BITS);
	endfunction

	function automatic lookup_t predict_lookup(logic signed [31:0] q);
		lookup_t r;
		int      first, cnt, stp, it, i0, i1;
		longint  num, den, w, a0, a1, d;
		r = '{default: '0};
		if (path_len == 0) begin
			r.status = STAT_EMPTY;
			return r;
		end
		first = 0;
		cnt = path_len;
		while (cnt > 0) begin
			stp = cnt / 2;
			it = first + stp;
			if (path_pts[it].s < q) begin
				first = it + 1;
				cnt -= stp + 1;
			end else begin
				cnt = stp;
			end
		end
		if (first == 0 || first >= path_len) begin
			i0 = (first == 0) ? 0 : path_len - 1;
			r.status = (first == 0) ? STAT_FIRST : STAT_LAST;
			r.s = path_pts[i0].s;
			r.x = path_pts[i0].x;
			r.y = path_pts[i0].y;
			r.hdg = path_pts[i0].heading;
			r.curv = path_pts[i0].curv;
			r.rate = path_pts[i0].rate;
			r.accel = path_pts[i0].accel;
			return r;
		end
		i0 = first - 1;
		i1 = first;
		num = longint'(q) - longint'(path_pts[i0].s);
		den = longint'(path_pts[i1].s) - longint'(path_pts[i0].s);
		if (den <= 0 || num <= 0)
			w = 0;
		else if (num >= den)
			w = longint'(1) << W_BITS;
		else
			w = (num << W_BITS) / den;
		r.status = STAT_INTERP;
		r.s = q;
		r.x = 32'(blend(path_pts[i0].x, path_pts[i1].x, w));
		r.y = 32'(blend(path_pts[i0].y, path_pts[i1].y, w));
		a0 = wrap_hdg(path_pts[i0].heading);
		a1 = wrap_hdg(path_pts[i1].heading);
		d = a1 - a0;
		if (d > HDG_PI)
			d -= HDG_TWO_PI;
		else if (d < -HDG_PI)
			d += HDG_TWO_PI;
		r.hdg = 31'(wrap_hdg(a0 + ((d * w) >>> W_BITS)));
		r.curv = 32'(blend(path_pts[i0].curv, path_pts[i1].curv, w));
		r.rate = 32'(blend(path_pts[i0].rate, path_pts[i1].rate, w));
		r.accel = 32'(blend(path_pts[i0].accel, path_pts[i1].accel, w));
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// compare each returned transaction with the oldest pending lookup
	always @(posedge clk) begin
		lookup_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				report("unexpected result, status", status, 0);
			end else begin
				e = pending_lookups.pop_front();
				if (out_s !== e.s) report("out_s", out_s, e.s);
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (out_heading !== e.hdg) report("out_heading", out_heading, e.hdg);
				if (out_curvature !== e.curv) report("out_curvature", out_curvature, e.curv);
				if (out_curvature_rate !== e.rate)
					report("out_curvature_rate", out_curvature_rate, e.rate);
				if (out_curvature_accel !== e.accel)
					report("out_curvature_accel", out_curvature_accel, e.accel);
				if (status !== e.status) report("status", status, e.status);
			end
		end
	end

	task automatic send(logic [1:0] op, logic signed [31:0] s, logic signed [31:0] x = 0,
			logic signed [31:0] y = 0, logic signed [30:0] h = 0,
			logic signed [31:0] c = 0, logic signed [31:0] cr = 0,
			logic signed [31:0] ca = 0);
		point_t p;
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		arc_s <= s;
		pos_x <= x;
		pos_y <= y;
		heading <= h;
		curvature <= c;
		curvature_rate <= cr;
		curvature_accel <= ca;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		case (op)
			OP_CLEAR: path_len = 0;
			OP_APPEND: begin
				if (path_len < PATH_DEPTH) begin
					p.s = s; p.x = x; p.y = y; p.heading = h;
					p.curv = c; p.rate = cr; p.accel = ca;
					path_pts[path_len] = p;
					path_len++;
				end
			end
			OP_QUERY: pending_lookups.insert(pending_lookups.size(), predict_lookup(s));
			default: ;
		endcase
	endtask

	function automatic logic signed [30:0] rand_hdg();
		return 31'(longint'($urandom_range(32'd1686629714)) - HDG_PI);
	endfunction

	task automatic append_rand(logic signed [31:0] s);
		send(OP_APPEND, s, $urandom, $urandom, rand_hdg(), $urandom, $urandom, $urandom);
	endtask

	task automatic test_empty_and_noop();
		send(OP_QUERY, 32'sd0);
		send(OP_NONE, $urandom);
		send(OP_QUERY, -32'sd2147483648);
		send(OP_CLEAR, $urandom);
		send(OP_QUERY, 32'sd2147483647);
	endtask

	task automatic test_extremes();
		send(OP_APPEND, -32'sd2147483648, -32'sd2147483648, 32'sd2147483647,
			-31'sd843314857, -32'sd2147483648, 32'sd2147483647, -32'sd2147483648);
		send(OP_QUERY, -32'sd2147483648);
		send(OP_QUERY, 32'sd5);
		send(OP_APPEND, 32'sd2147483647, 32'sd2147483647, -32'sd2147483648,
			31'sd843314857, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647);
		send(OP_QUERY, 32'sd0);
		send(OP_QUERY, 32'sd2147483646);
		send(OP_QUERY, 32'sd2147483647);
		send(OP_CLEAR, 0);
		// headings across the wrap point take the shorter arc
		send(OP_APPEND, 32'sd0, 0, 0, 31'sd800000000);
		send(OP_APPEND, 32'sd65536, 0, 0, -31'sd800000000);
		send(OP_APPEND, 32'sd65536, 5, 5, 31'sd100);        // zero span
		send(OP_APPEND, 32'sd0, 7, 7, -31'sd843314857);     // unsorted
		send(OP_APPEND, 32'sd200000, 9, 9, 31'sd843314857);
		send(OP_QUERY, 32'sd32768);
		send(OP_QUERY, 32'sd65536);
		send(OP_QUERY, 32'sd100000);
		send(OP_QUERY, 32'sd300000);
		send(OP_QUERY, 32'sd1);
	endtask

	task automatic test_full_store();
		send(OP_CLEAR, 0);
		for (int i = 0; i < PATH_DEPTH + 4; i++)
			append_rand(32'(i * 4096 - 2000000));
		for (int i = 0; i < 12; i++)
			send(OP_QUERY, 32'($urandom_range(4300000)) - 32'sd2100000);
	endtask

	task automatic test_random_paths(int budget);
		logic signed [31:0] base, lo, hi;
		int n, m, stepmax, start;
		start = items_sent;
		while (items_sent < budget) begin
			// hold the middle half of this section free of idle cycles
			calm = (items_sent - start > (budget - start) / 4) &&
			       (items_sent - start < 3 * (budget - start) / 4);
			if ($urandom_range(99) < 85) begin
				send(OP_CLEAR, $urandom);
				n = ($urandom_range(19) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
				stepmax = 1 << $urandom_range(22, 2);
				base = $urandom;
				if (base > 32'sd1000000000) base = base - 32'sd1500000000;
				lo = base;
				for (int i = 0; i < n; i++) begin
					append_rand(base);
					hi = base;
					base = base + $urandom_range(stepmax);
				end
				m = $urandom_range(12, 1);
				for (int i = 0; i < m; i++) begin
					case ($urandom_range(9))
						0: send(OP_QUERY, lo - $urandom_range(1000));
						1: send(OP_QUERY, hi + $urandom_range(1000));
						2: send(OP_QUERY, path_pts[$urandom_range(path_len - 1)].s);
						3: send(OP_QUERY, $urandom);
						default: send(OP_QUERY, lo + 32'($urandom_range(32'(hi - lo))));
					endcase
				end
			end else begin
				case ($urandom_range(3))
					0: send(OP_NONE, $urandom, $urandom, $urandom, rand_hdg());
					1: append_rand($urandom);
					2: send(OP_QUERY, $urandom);
					default: send(OP_CLEAR, $urandom);
				endcase
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_noop();
		test_extremes();
		test_full_store();
		test_random_paths(1150);
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/ppi_pkg.sv
hdl/ppi_ram.sv
hdl/ppi_div.sv
hdl/ppi_lerp.sv
hdl/path_point_interpolator.sv
hdl/ppi_checker.sv
tb/tb_path_point_interpolator.sv
